@@ src/double_to_single_exact_narrow_unit_defines.svh @@
// assertion macros for the double to single exact narrowing unit
// used by the top level only; expects clk and rst_n in the including scope
`ifndef DOUBLE_TO_SINGLE_EXACT_NARROW_UNIT_DEFINES_SVH
`define DOUBLE_TO_SINGLE_EXACT_NARROW_UNIT_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define DTSEN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while in reset
`define DTSEN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dtsen_pkg.sv @@
// shared types and constants for the double to single exact narrowing unit
// no dependencies
package dtsen_pkg;

    localparam int DOUBLE_W = 64;
    localparam int SINGLE_W = 32;
    localparam int MANT_W   = 52;
    localparam int EXP_W    = 11;
    localparam int SHIFT_W  = 6;
    localparam int SEXP_W   = 8;
    localparam int LOST_W   = 29;

    localparam logic [EXP_W-1:0] EXP_ZERO     = 11'd0;
    localparam logic [EXP_W-1:0] SUB_LO_EXP   = 11'd874;
    localparam logic [EXP_W-1:0] NORM_LO_EXP  = 11'd898;
    localparam logic [EXP_W-1:0] SUB_SHIFT_AT = 11'd926;
    localparam logic [EXP_W-1:0] NORM_HI_EXP  = 11'd1150;
    localparam logic [EXP_W-1:0] BIAS_DIFF    = 11'd896;
    localparam logic [EXP_W-1:0] EXP_TOP      = 11'd2047;

    localparam logic [MANT_W-1:0]   DQNAN_MANT = 52'h8_0000_0000_0000;
    localparam logic [SINGLE_W-1:0] SINF_BITS  = 32'h7f80_0000;
    localparam logic [SINGLE_W-1:0] SQNAN_BITS = 32'h7fc0_0000;

    typedef enum logic [2:0] {
        CLS_FAIL,
        CLS_ZERO,
        CLS_SUB,
        CLS_NORM,
        CLS_INF,
        CLS_QNAN
    } cls_t;

    typedef struct packed {
        cls_t               cls;
        logic               sign;
        logic [MANT_W-1:0]  man;
        logic [SHIFT_W-1:0] sub_shift;
        logic [SEXP_W-1:0]  norm_exp;
    } decode_t;

endpackage

@@ src/dtsen_decode.sv @@
// first stage logic: splits a binary64 pattern and classifies it by exponent
// depends on dtsen_pkg
module dtsen_decode (
    input  logic [dtsen_pkg::DOUBLE_W-1:0] double_bits,
    output dtsen_pkg::decode_t             dec
);

    logic [dtsen_pkg::EXP_W-1:0]  ex;
    logic [dtsen_pkg::MANT_W-1:0] man;
    logic                         sign;
    logic                         man_zero;
    logic                         low_zero;
    logic [dtsen_pkg::EXP_W-1:0]  shift_full;
    logic [dtsen_pkg::EXP_W-1:0]  exp_full;

    assign sign       = double_bits[dtsen_pkg::DOUBLE_W-1];
    assign ex         = double_bits[dtsen_pkg::DOUBLE_W-2 -: dtsen_pkg::EXP_W];
    assign man        = double_bits[dtsen_pkg::MANT_W-1:0];
    assign man_zero   = (man == '0);
    assign low_zero   = (man[dtsen_pkg::LOST_W-1:0] == '0);
    assign shift_full = dtsen_pkg::SUB_SHIFT_AT - ex;
    assign exp_full   = ex - dtsen_pkg::BIAS_DIFF;

    always_comb
    begin
        dec.sign      = sign;
        dec.man       = man;
        dec.sub_shift = shift_full[dtsen_pkg::SHIFT_W-1:0];
        dec.norm_exp  = exp_full[dtsen_pkg::SEXP_W-1:0];
        dec.cls       = dtsen_pkg::CLS_FAIL;
        if (ex == dtsen_pkg::EXP_ZERO)
        begin
            if (man_zero)
                dec.cls = dtsen_pkg::CLS_ZERO;
        end
        else if (ex >= dtsen_pkg::SUB_LO_EXP && ex < dtsen_pkg::NORM_LO_EXP)
        begin
            // lost bits depend on the shift, checked in the next stage
            dec.cls = dtsen_pkg::CLS_SUB;
        end
        else if (ex >= dtsen_pkg::NORM_LO_EXP && ex <= dtsen_pkg::NORM_HI_EXP)
        begin
            if (low_zero)
                dec.cls = dtsen_pkg::CLS_NORM;
        end
        else if (ex == dtsen_pkg::EXP_TOP)
        begin
            if (man_zero)
                dec.cls = dtsen_pkg::CLS_INF;
            else if (man == dtsen_pkg::DQNAN_MANT && !sign)
                dec.cls = dtsen_pkg::CLS_QNAN;
        end
    end

endmodule

@@ src/dtsen_assemble.sv @@
// second stage logic: subnormal shift, lost bit check and result packing
// depends on dtsen_pkg
module dtsen_assemble (
    input  dtsen_pkg::decode_t               dec,
    output logic [dtsen_pkg::SINGLE_W-1:0]   single_bits,
    output logic                             fits
);

    localparam int SIG_W = dtsen_pkg::MANT_W + 1;

    logic [SIG_W-1:0] sig;
    logic [SIG_W-1:0] shifted;
    logic [SIG_W-1:0] lost_mask;
    logic             lost;

    assign sig       = {1'b1, dec.man};
    assign shifted   = sig >> dec.sub_shift;
    assign lost_mask = (SIG_W'(1) << dec.sub_shift) - SIG_W'(1);
    assign lost      = |(dec.man & lost_mask[dtsen_pkg::MANT_W-1:0]);

    always_comb
    begin
        single_bits = '0;
        fits        = 1'b0;
        case (dec.cls)
            dtsen_pkg::CLS_ZERO:
            begin
                single_bits = {dec.sign, {(dtsen_pkg::SINGLE_W-1){1'b0}}};
                fits        = 1'b1;
            end
            dtsen_pkg::CLS_SUB:
            begin
                // exponent 897 carries the hidden one into the exponent field
                if (!lost)
                begin
                    single_bits = {dec.sign, shifted[dtsen_pkg::SINGLE_W-2:0]};
                    fits        = 1'b1;
                end
            end
            dtsen_pkg::CLS_NORM:
            begin
                single_bits = {dec.sign, dec.norm_exp,
                               dec.man[dtsen_pkg::MANT_W-1:dtsen_pkg::LOST_W]};
                fits        = 1'b1;
            end
            dtsen_pkg::CLS_INF:
            begin
                single_bits = {dec.sign, dtsen_pkg::SINF_BITS[dtsen_pkg::SINGLE_W-2:0]};
                fits        = 1'b1;
            end
            dtsen_pkg::CLS_QNAN:
            begin
                single_bits = dtsen_pkg::SQNAN_BITS;
                fits        = 1'b1;
            end
            default:
            begin
                single_bits = '0;
                fits        = 1'b0;
            end
        endcase
    end

endmodule

@@ src/double_to_single_exact_narrow_unit.sv @@
// top level of the double to single exact narrowing unit: three stage stream pipeline
// depends on dtsen_pkg, dtsen_decode, dtsen_assemble and the assertion macro header
`include "double_to_single_exact_narrow_unit_defines.svh"

// This unit takes one raw binary64 pattern per transfer and returns the binary32 pattern of
// the same value together with a fits flag, which is set only when the narrowing is exact:
// signed zero, exact single subnormals, exact normals, signed infinity and the positive
// canonical quiet nan (returned as 0x7fc00000). Every other input gives fits low and a zero
// data word. Each item passes three register stages (input capture, decode, packed result),
// and its result is held in the packed result stage until the output side takes it; one
// transfer per cycle is sustained while the output side stays ready. Each stage
// has its own valid bit and advances when it is empty or the stage after it moves, so
// bubbles close up under backpressure and a stall neither drops nor repeats an item. There
// is no configuration and no state beyond the pipeline itself.
module double_to_single_exact_narrow_unit (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dtsen_pkg::DOUBLE_W-1:0] s_axis_tdata,  // [63:0] double_bits

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dtsen_pkg::SINGLE_W-1:0] m_axis_tdata,  // [31:0] single_bits
    output logic                          m_axis_tuser   // [0] fits
);

    // stage valid bits
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;

    // stage payloads
    logic [dtsen_pkg::DOUBLE_W-1:0] d1_reg;
    dtsen_pkg::decode_t             dec2_reg;
    logic [dtsen_pkg::SINGLE_W-1:0] res3_reg;
    logic                           fits3_reg;

    // per-stage advance
    logic ready1;
    logic ready2;
    logic ready3;

    dtsen_pkg::decode_t             dec1;
    logic [dtsen_pkg::SINGLE_W-1:0] res2;
    logic                           fits2;

    // a stage may load when it is empty or its item moves on this cycle
    assign ready3 = !v3_reg || m_axis_tready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign s_axis_tready = ready1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = res3_reg;
    assign m_axis_tuser  = fits3_reg;

    // exponent classification of the captured pattern
    dtsen_decode u_decode (
        .double_bits (d1_reg),
        .dec         (dec1)
    );

    // subnormal shift and packing of the single pattern
    dtsen_assemble u_assemble (
        .dec         (dec2_reg),
        .single_bits (res2),
        .fits        (fits2)
    );

    always_comb
    begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        if (ready1)
            v1_next = s_axis_tvalid;
        if (ready2)
            v2_next = v1_reg;
        if (ready3)
            v3_next = v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // payloads carry no reset, they load only alongside their valid bit
    always_ff @(posedge clk)
    begin
        if (ready1 && s_axis_tvalid)
            d1_reg <= s_axis_tdata;
        if (ready2 && v1_reg)
            dec2_reg <= dec1;
        if (ready3 && v2_reg)
        begin
            res3_reg  <= res2;
            fits3_reg <= fits2;
        end
    end

    // a rejected value always leaves a zero data word
    `DTSEN_ASSERT_NOW(a_nofit_zero, v3_reg && !fits3_reg, res3_reg == '0,
        "nonzero data with fits low")

    // an all-ones exponent only leaves as infinity or the canonical quiet nan
    `DTSEN_ASSERT_NOW(a_top_exp, v3_reg && fits3_reg && res3_reg[30:23] == 8'hff,
        res3_reg[22:0] == '0 || res3_reg == dtsen_pkg::SQNAN_BITS,
        "bad nan or infinity pattern")

    // an input transfer always lands in the first stage
    `DTSEN_ASSERT_NEXT(a_in_capture, s_axis_tvalid && s_axis_tready, v1_reg,
        "input transfer lost")

    // a decoded item moves into an empty output stage without delay
    `DTSEN_ASSERT_NEXT(a_mid_advance, v2_reg && !v3_reg, v3_reg,
        "middle stage item stuck")

endmodule

@@ sim/testbench.sv @@
// testbench for double_to_single_exact_narrow_unit: directed and random binary64 patterns
// a scoreboard class predicts each binary32 result and fits flag; needs dtsen_pkg and the rtl
`timescale 1ns / 100ps

module testbench;

    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [dtsen_pkg::EXP_W-1:0] exp_field_t;

    // expected output transfer: narrowed pattern and exactness flag
    typedef struct packed {
        logic [dtsen_pkg::SINGLE_W-1:0] bits;
        logic                           fits;
    } single_result_t;

    // holds the singles still owed by the unit, in transfer order
    class single_result_board;
        single_result_t expected_singles[$];
        int             mismatches;

        function new();
            mismatches = 0;
        endfunction

        // exact binary64 to binary32 narrowing, zero pattern when inexact
        function single_result_t narrow_exact(input logic [dtsen_pkg::DOUBLE_W-1:0] d);
            single_result_t                 r;
            logic                           sign;
            logic [dtsen_pkg::EXP_W-1:0]    ex;
            logic [dtsen_pkg::MANT_W-1:0]   man;
            logic [dtsen_pkg::EXP_W-1:0]    sexp;
            logic [dtsen_pkg::DOUBLE_W-1:0] lost_mask;
            logic [dtsen_pkg::DOUBLE_W-1:0] shifted;
            int unsigned                    sh;
            sign = d[dtsen_pkg::DOUBLE_W-1];
            ex   = d[dtsen_pkg::DOUBLE_W-2:dtsen_pkg::MANT_W];
            man  = d[dtsen_pkg::MANT_W-1:0];
            r    = '0;
            if (ex == dtsen_pkg::EXP_ZERO) begin
                // signed zero only; double subnormals never fit
                if (man == '0) begin
                    r.bits = {sign, 31'd0};
                    r.fits = 1'b1;
                end
            end
            else if (ex >= dtsen_pkg::SUB_LO_EXP && ex < dtsen_pkg::NORM_LO_EXP) begin
                // single subnormal range, hidden one shifted into the fraction
                sh        = 32'(dtsen_pkg::SUB_SHIFT_AT - ex);
                lost_mask = (64'd1 << sh) - 64'd1;
                if (({12'd0, man} & lost_mask) == '0) begin
                    shifted = {12'd1, man} >> sh;
                    r.bits  = {sign, shifted[30:0]};
                    r.fits  = 1'b1;
                end
            end
            else if (ex >= dtsen_pkg::NORM_LO_EXP && ex <= dtsen_pkg::NORM_HI_EXP) begin
                if (man[dtsen_pkg::LOST_W-1:0] == '0) begin
                    sexp   = ex - dtsen_pkg::BIAS_DIFF;
                    r.bits = {sign, sexp[dtsen_pkg::SEXP_W-1:0],
                              man[dtsen_pkg::MANT_W-1:dtsen_pkg::LOST_W]};
                    r.fits = 1'b1;
                end
            end
            else if (ex == dtsen_pkg::EXP_TOP) begin
                if (man == '0) begin
                    r.bits = {sign, dtsen_pkg::SINF_BITS[30:0]};
                    r.fits = 1'b1;
                end
                else if (man == dtsen_pkg::DQNAN_MANT && !sign) begin
                    r.bits = dtsen_pkg::SQNAN_BITS;
                    r.fits = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_double(input logic [dtsen_pkg::DOUBLE_W-1:0] d);
            expected_singles.push_back(narrow_exact(d));
        endfunction

        function void check_single(input logic [dtsen_pkg::SINGLE_W-1:0] bits,
                                   input logic fits);
            single_result_t want;
            if (expected_singles.size() == 0) begin
                $error("unexpected result: single_bits %h fits %b", bits, fits);
                mismatches++;
            end
            else begin
                want = expected_singles.pop_front();
                if (bits !== want.bits) begin
                    $error("single_bits mismatch: expected %h, actual %h", want.bits, bits);
                    mismatches++;
                end
                if (fits !== want.fits) begin
                    $error("fits mismatch: expected %b, actual %b", want.fits, fits);
                    mismatches++;
                end
            end
        endfunction

        function int owed();
            return expected_singles.size();
        endfunction
    endclass

    // corner patterns: zeros, subnormal edges, carry into the smallest normal,
    // normal range edges, out of range, infinities and nans
    localparam logic [dtsen_pkg::DOUBLE_W-1:0] DIRECTED_DOUBLES [25] = '{
        64'h0000_0000_0000_0000,  // +0
        64'h8000_0000_0000_0000,  // -0
        64'h0000_0000_0000_0001,  // double subnormal
        64'h800F_FFFF_FFFF_FFFF,  // largest negative double subnormal
        64'h36A0_0000_0000_0000,  // smallest single subnormal
        64'hB6A0_0000_0000_0000,  // its negative
        64'h36A0_0000_0000_0001,  // smallest subnormal plus a lost bit
        64'h36B8_0000_0000_0000,  // three times the smallest subnormal
        64'h380F_FFFF_C000_0000,  // largest single subnormal
        64'h380F_FFFF_E000_0000,  // one bit too many for the subnormal
        64'h3810_0000_0000_0000,  // hidden one carries into smallest normal
        64'h381F_FFFF_E000_0000,  // top of the carry exponent
        64'h3810_0000_1000_0000,  // carry exponent with a lost bit
        64'h3820_0000_0000_0000,  // first normal exponent
        64'h3FF0_0000_0000_0000,  // 1.0
        64'hBFF8_0000_0000_0000,  // -1.5
        64'h47EF_FFFF_E000_0000,  // largest single
        64'h47F0_0000_0000_0000,  // just above range
        64'h3690_0000_0000_0000,  // just below range
        64'h7FF0_0000_0000_0000,  // +inf
        64'hFFF0_0000_0000_0000,  // -inf
        64'h7FF8_0000_0000_0000,  // positive canonical quiet nan
        64'hFFF8_0000_0000_0000,  // negative quiet nan
        64'h7FF0_0000_0000_0001,  // signaling nan
        64'h7FF8_0000_0000_0001   // quiet nan with payload
    };

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [dtsen_pkg::DOUBLE_W-1:0] s_axis_tdata;   // [63:0] double_bits
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [dtsen_pkg::SINGLE_W-1:0] m_axis_tdata;   // [31:0] single_bits
    logic                           m_axis_tuser;   // [0] fits

    single_result_board board = new();

    // idling on both sides, switched off for the closing stretch
    bit idle_on      = 1'b1;
    // asks the result side for one long hold-off
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    double_to_single_exact_narrow_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // transfers are seen with the values held just before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_double(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_single(m_axis_tdata, m_axis_tuser);
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // weighted mix: mostly exact and near-exact values with random content,
    // the rest specials, out of range exponents and raw noise
    function automatic logic [dtsen_pkg::DOUBLE_W-1:0] pick_double();
        int unsigned                    kind;
        int unsigned                    sh;
        logic                           sign;
        logic [dtsen_pkg::EXP_W-1:0]    ex;
        logic [dtsen_pkg::MANT_W-1:0]   man;
        logic [dtsen_pkg::DOUBLE_W-1:0] raw;
        kind = $urandom_range(99);
        sign = 1'($urandom_range(1));
        raw  = {$urandom, $urandom};
        man  = raw[dtsen_pkg::MANT_W-1:0];
        ex   = exp_field_t'($urandom_range(2047));
        if (kind < 30)
        begin
            ex                         = exp_field_t'($urandom_range(1150, 898));
            man[dtsen_pkg::LOST_W-1:0] = '0;
        end
        else if (kind < 60)
        begin
            // exact subnormal or normal, a third of them with one lost bit set
            ex  = (kind < 45) ? exp_field_t'($urandom_range(897, 874))
                              : exp_field_t'($urandom_range(1150, 874));
            sh  = (ex < dtsen_pkg::NORM_LO_EXP) ? 32'(dtsen_pkg::SUB_SHIFT_AT - ex)
                                                : 32'(dtsen_pkg::LOST_W);
            raw = {12'd0, man} & ~((64'd1 << sh) - 64'd1);
            man = raw[dtsen_pkg::MANT_W-1:0];
            if (kind >= 50)
                man = man | (52'd1 << $urandom_range(sh - 1));
        end
        else if (kind < 75)
        begin
            case ($urandom_range(5))
                0: begin ex = dtsen_pkg::EXP_ZERO; man = '0; end
                1: ex = dtsen_pkg::EXP_ZERO;
                2: begin ex = dtsen_pkg::EXP_TOP; man = '0; end
                3: begin ex = dtsen_pkg::EXP_TOP; man = dtsen_pkg::DQNAN_MANT; end
                4: ex = dtsen_pkg::EXP_TOP;
                default:
                begin
                    ex  = dtsen_pkg::EXP_TOP;
                    man = dtsen_pkg::DQNAN_MANT
                        | (52'd1 << $urandom_range(dtsen_pkg::MANT_W - 1));
                end
            endcase
        end
        else if (kind < 85)
            ex = $urandom_range(1) ? exp_field_t'($urandom_range(873, 1))
                                   : exp_field_t'($urandom_range(2046, 1151));
        else
            return {$urandom, $urandom};
        return {sign, ex, man};
    endfunction

    // offer one double and hold it until the unit takes it
    task automatic send_double(input logic [dtsen_pkg::DOUBLE_W-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
    endtask

    // random source gap before an item
    task automatic maybe_gap();
        if (idle_on && $urandom_range(3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clk);
        end
    endtask

    task automatic send_random(input int count, input bit with_gaps);
        for (int i = 0; i < count; i++)
        begin
            if (with_gaps)
                maybe_gap();
            send_double(pick_double());
        end
    endtask

    // source goes quiet until every owed single has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.owed() != 0);
    endtask

    // result side: random stall bursts, free-running stretches, one long hold
    initial
    begin
        m_axis_tready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (idle_on && $urandom_range(3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(14, 1)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_DOUBLES[i])
        begin
            maybe_gap();
            send_double(DIRECTED_DOUBLES[i]);
        end

        send_random(150, 1'b1);

        // long result stall while the source keeps pushing back to back
        hold_request = 1'b1;
        send_random(30, 1'b0);
        wait_drained();

        send_random(170, 1'b1);

        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        send_random(50, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/dtsen_pkg.sv
src/dtsen_decode.sv
src/dtsen_assemble.sv
src/double_to_single_exact_narrow_unit.sv
sim/testbench.sv
